// ===== src/gcb_pkg.sv =====
package gcb_pkg;

	// default screen size
	localparam int SCREEN_W_DEF = 320;
	localparam int SCREEN_H_DEF = 240;

	// command codes
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_COVER = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// fixed field widths
	localparam int CRD_W   = 12;
	localparam int RADDR_W = 17;
	localparam int WORD_W  = 16;

	// result queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int CRED_W   = $clog2(OQ_DEPTH + 1);

	// one operation handed from the cursor stage to the store pipeline
	typedef struct packed {
		logic               rd;    // read beat, else pixel write
		logic               mode;  // 1: packed 4-bit gray
		logic               inr;   // read address inside the store
		logic [CRD_W-1:0]   x;
		logic [CRD_W-1:0]   y;
		logic [7:0]         v;     // gray level 255 - coverage
		logic [RADDR_W-1:0] raddr;
	} blit_op_t;

endpackage

// ===== src/glyph_coverage_blitter_top.sv =====
// Channel | Direction | Handshake           | Beat carries
// in      | input     | in_valid / in_ready | cmd, pos_x, pos_y, glyph_width, glyph_rows,
//         |           |                     | coverage, read_address
// out     | output    | out_valid/out_ready | read_data
// cfg     | input     | cfg_we (no wait)    | cfg_wdata = screen_mode
//
// One input beat per cycle while in_ready is high. A read returns its word through the
// cursor stage, address multiply, store read and result queue. Eight reads may be
// outstanding; in_ready drops while the result queue holds their credits.
// After reset the frame store is swept to all ones, one word a cycle, covering
// all SCREEN_W*SCREEN_H words (76800 at 320x240) with in_ready low; cfg writes go on.
// Output stalls never stall the write pipeline, but held credits also block pixel writes.
module glyph_coverage_blitter_top #(
	parameter int SCREEN_W = gcb_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = gcb_pkg::SCREEN_H_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic [7:0]         glyph_width,
	input  logic [7:0]         glyph_rows,
	input  logic [7:0]         coverage,
	input  logic [16:0]        read_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        read_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	logic              acc;
	logic              take;
	logic              busy;
	logic              credit_ok;
	logic              op_vld_s1;
	gcb_pkg::blit_op_t op_s1;
	logic              res_vld;
	logic [15:0]       res_data;

	// accept needs the sweep finished and a free result slot
	assign in_ready = !busy && credit_ok;
	assign acc      = in_valid && in_ready;
	assign take     = acc && (cmd == gcb_pkg::CMD_READ);

	// command decode, glyph cursor, clipping
	gcb_walk #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (acc),
		.cmd          (cmd),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.glyph_width  (glyph_width),
		.glyph_rows   (glyph_rows),
		.coverage     (coverage),
		.read_address (read_address),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.op_vld_s1    (op_vld_s1),
		.op_s1        (op_s1)
	);

	// address, store read, nibble merge with forwarding, write-back
	gcb_rmw #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_vld_s1 (op_vld_s1),
		.op_s1     (op_s1),
		.res_vld   (res_vld),
		.res_data  (res_data),
		.busy      (busy)
	);

	// result queue with read credits
	gcb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.push      (res_vld),
		.push_data (res_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.read_data (read_data),
		.credit_ok (credit_ok)
	);

endmodule

// ===== src/gcb_walk.sv =====
module gcb_walk #(
	parameter int SCREEN_W = gcb_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = gcb_pkg::SCREEN_H_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic [1:0]                  cmd,
	input  logic signed [11:0]          pos_x,
	input  logic signed [11:0]          pos_y,
	input  logic [7:0]                  glyph_width,
	input  logic [7:0]                  glyph_rows,
	input  logic [7:0]                  coverage,
	input  logic [16:0]                 read_address,
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	output logic                        op_vld_s1,
	output gcb_pkg::blit_op_t           op_s1
);

	localparam int DEPTH = SCREEN_W * SCREEN_H;
	localparam int AW    = $clog2(DEPTH);
	localparam int CMP_W = (AW + 1 > gcb_pkg::RADDR_W) ? AW + 1 : gcb_pkg::RADDR_W;

	logic        mode_q;
	logic [11:0] org_col_q;
	logic [11:0] org_row_q;
	logic [7:0]  span_cols_q;
	logic [7:0]  span_rows_q;
	logic [7:0]  col_q;
	logic [8:0]  row_q;

	logic        live;
	logic        wrap;
	logic [8:0]  col_nx;
	logic [12:0] x;
	logic [12:0] y;
	logic        onscr;
	logic        draw;
	logic        inr;

	always_comb begin
		live   = (span_cols_q != 8'd0) && (row_q < {1'b0, span_rows_q});
		col_nx = {1'b0, col_q} + 9'd1;
		wrap   = col_nx >= {1'b0, span_cols_q};
		x      = {org_col_q[11], org_col_q} + {5'd0, col_q};
		y      = {org_row_q[11], org_row_q} + {4'd0, row_q};
		onscr  = !x[12] && !y[12] && (x < 13'(SCREEN_W)) && (y < 13'(SCREEN_H));
		draw   = live && (coverage != 8'd0) && onscr;
		inr    = CMP_W'(read_address) < CMP_W'(DEPTH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// glyph cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_col_q   <= '0;
			org_row_q   <= '0;
			span_cols_q <= '0;
			span_rows_q <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else if (acc) begin
			case (cmd)
				gcb_pkg::CMD_BEGIN: begin
					org_col_q   <= pos_x;
					org_row_q   <= pos_y;
					span_cols_q <= glyph_width;
					span_rows_q <= glyph_rows;
					col_q       <= '0;
					row_q       <= '0;
				end
				gcb_pkg::CMD_COVER: begin
					if (live) begin
						if (wrap) begin
							col_q <= '0;
							row_q <= row_q + 9'd1;
						end else begin
							col_q <= col_nx[7:0];
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_vld_s1 <= 1'b0;
		end else begin
			op_vld_s1 <= acc && ((cmd == gcb_pkg::CMD_READ) ||
				((cmd == gcb_pkg::CMD_COVER) && draw));
		end
	end

	always_ff @(posedge clk) begin
		op_s1.rd    <= (cmd == gcb_pkg::CMD_READ);
		op_s1.mode  <= mode_q;
		op_s1.inr   <= inr;
		op_s1.x     <= x[11:0];
		op_s1.y     <= y[11:0];
		op_s1.v     <= ~coverage;
		op_s1.raddr <= read_address;
	end

endmodule

// ===== src/gcb_store.sv =====
module gcb_store #(
	parameter int DEPTH = gcb_pkg::SCREEN_W_DEF * gcb_pkg::SCREEN_H_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [gcb_pkg::WORD_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [gcb_pkg::WORD_W-1:0]  rdata,
	output logic                        busy
);

	localparam logic [gcb_pkg::WORD_W-1:0] CLEAR_WORD = '1;

	logic [gcb_pkg::WORD_W-1:0] mem [DEPTH];

	logic                       busy_q;
	logic [AW-1:0]              clr_q;
	logic                       wr_en;
	logic [AW-1:0]              wr_a;
	logic [gcb_pkg::WORD_W-1:0] wr_d;

	assign busy  = busy_q;
	assign wr_en = busy_q || we;
	assign wr_a  = busy_q ? clr_q : waddr;
	assign wr_d  = busy_q ? CLEAR_WORD : wdata;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_a] <= wr_d;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/gcb_rmw.sv =====
module gcb_rmw #(
	parameter int SCREEN_W = gcb_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = gcb_pkg::SCREEN_H_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        op_vld_s1,
	input  gcb_pkg::blit_op_t           op_s1,
	output logic                        res_vld,
	output logic [gcb_pkg::WORD_W-1:0]  res_data,
	output logic                        busy
);

	localparam int DEPTH = SCREEN_W * SCREEN_H;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(SCREEN_W);
	localparam int YW    = $clog2(SCREEN_H);

	logic [AW-1:0] pix;
	logic [AW-1:0] addr;

	logic          vld_s2;
	logic          rd_s2;
	logic          mode_s2;
	logic          inr_s2;
	logic [AW-1:0] addr_s2;
	logic [1:0]    nib_s2;
	logic [7:0]    v_s2;

	logic                       vld_s3;
	logic                       rd_s3;
	logic                       mode_s3;
	logic                       inr_s3;
	logic [AW-1:0]              addr_s3;
	logic [1:0]                 nib_s3;
	logic [7:0]                 v_s3;
	logic                       fwd_s3;
	logic [gcb_pkg::WORD_W-1:0] fwd_data_s3;

	logic [gcb_pkg::WORD_W-1:0] rdata;
	logic [gcb_pkg::WORD_W-1:0] old_word;
	logic [gcb_pkg::WORD_W-1:0] new_word;
	logic                       we;
	logic [3:0]                 g;

	// pixel index y*W + x, word index depends on format
	always_comb begin
		pix = AW'(AW'(op_s1.y[YW-1:0]) * AW'(SCREEN_W)) + AW'(op_s1.x[XW-1:0]);
		if (op_s1.rd) begin
			addr = AW'(op_s1.raddr);
		end else if (op_s1.mode) begin
			addr = pix >> 2;
		end else begin
			addr = pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= op_vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rd_s2   <= op_s1.rd;
		mode_s2 <= op_s1.mode;
		inr_s2  <= op_s1.inr;
		addr_s2 <= addr;
		nib_s2  <= pix[1:0];
		v_s2    <= op_s1.v;

		rd_s3   <= rd_s2;
		mode_s3 <= mode_s2;
		inr_s3  <= inr_s2;
		addr_s3 <= addr_s2;
		nib_s3  <= nib_s2;
		v_s3    <= v_s2;
		// write in flight to the word being read: take its data instead
		fwd_s3      <= we && (addr_s3 == addr_s2);
		fwd_data_s3 <= new_word;
	end

	gcb_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (addr_s3),
		.wdata  (new_word),
		.raddr  (addr_s2),
		.rdata  (rdata),
		.busy   (busy)
	);

	// merge
	always_comb begin
		old_word = fwd_s3 ? fwd_data_s3 : rdata;
		g        = v_s3[7:4];
		new_word = old_word;
		if (!mode_s3) begin
			new_word = {v_s3[7:3], v_s3[7:2], v_s3[7:3]};
		end else begin
			case (nib_s3)
				2'd0:    new_word[7:4]   = g;
				2'd1:    new_word[3:0]   = g;
				2'd2:    new_word[15:12] = g;
				default: new_word[11:8]  = g;
			endcase
		end
		we       = vld_s3 && !rd_s3;
		res_vld  = vld_s3 && rd_s3;
		res_data = inr_s3 ? old_word : '0;
	end

endmodule

// ===== src/gcb_outq.sv =====
module gcb_outq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic                        push,
	input  logic [gcb_pkg::WORD_W-1:0]  push_data,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [gcb_pkg::WORD_W-1:0]  read_data,
	output logic                        credit_ok
);

	logic [gcb_pkg::WORD_W-1:0] buf_q [gcb_pkg::OQ_DEPTH];
	logic [gcb_pkg::OQ_AW-1:0]  wp_q;
	logic [gcb_pkg::OQ_AW-1:0]  rp_q;
	logic [gcb_pkg::CRED_W-1:0] cnt_q;
	logic [gcb_pkg::CRED_W-1:0] cred_q;
	logic                       pop;

	assign out_valid = cnt_q != '0;
	assign read_data = buf_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign credit_ok = cred_q < gcb_pkg::CRED_W'(gcb_pkg::OQ_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

	// cred_q: reads accepted and not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
			cred_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + gcb_pkg::OQ_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + gcb_pkg::OQ_AW'(1);
			end
			cnt_q  <= cnt_q + gcb_pkg::CRED_W'(push) - gcb_pkg::CRED_W'(pop);
			cred_q <= cred_q + gcb_pkg::CRED_W'(take) - gcb_pkg::CRED_W'(pop);
		end
	end

endmodule

// ===== src/gcb_check.sv =====
module gcb_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] read_data
);

	logic [gcb_pkg::CRED_W-1:0] pend_q;
	logic                       rd_acc;
	logic                       out_acc;

	assign rd_acc  = in_valid && in_ready && (cmd == gcb_pkg::CMD_READ);
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + gcb_pkg::CRED_W'(rd_acc) - gcb_pkg::CRED_W'(out_acc);
		end
	end

	// no result beat without an undelivered read
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result beat with no read pending");

	// ready only while a result slot is free
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> pend_q < gcb_pkg::CRED_W'(gcb_pkg::OQ_DEPTH))
		else $error("input accepted beyond result capacity");

	// store sweep holds the input off straight after reset
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready)
		else $error("input ready during clearing sweep");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data))
		else $error("stalled result beat changed");

endmodule

bind glyph_coverage_blitter_top gcb_check u_gcb_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data)
);
